### rtl/bacs_pkg.sv
package bacs_pkg;

    // Stream payload widths
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 168;
    localparam int CNT_OUT_W   = 32;
    localparam int RATIO_OUT_W = 17;
    localparam int OUT_PAD_W   = OUT_DATA_W - 4 * CNT_OUT_W - 2 * RATIO_OUT_W;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_FORMAT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CLEAR_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLACK_LIMIT     = 2'd2;

    // Block formats
    localparam logic FMT_BC2 = 1'b0;
    localparam logic FMT_BC1 = 1'b1;

    // Reset values of the registers
    localparam logic [4:0]  CLEAR_THRESHOLD_RST = 5'd8;
    localparam logic [15:0] BLACK_LIMIT_RST     = 16'h1082;

    localparam int TEXELS_PER_BLOCK = 16;

    // Count index-3 texels of an 8-byte block; only when c0 <= c1
    function automatic logic [4:0] count_bc1_zeros(input logic [63:0] blk);
        logic [4:0] n;
        n = '0;
        if (blk[15:0] <= blk[31:16])
        begin
            for (int i = 0; i < 16; i++)
            begin
                n = n + 5'(blk[32 + 2 * i +: 2] == 2'h3);
            end
        end
        return n;
    endfunction

    // Count zero alpha nibbles of a 16-byte block
    function automatic logic [4:0] count_bc2_zeros(input logic [63:0] alpha);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++)
        begin
            n = n + 5'(alpha[4 * i +: 4] == 4'h0);
        end
        return n;
    endfunction

endpackage

### rtl/block_alpha_coverage_stats.sv
// Alpha coverage statistics over a stream of BC1 / BC2 compressed 4x4 blocks.
//
// Input channel s_*: one block per item. s_tdata[63:0] is the first word
// (alpha nibbles, or the whole block in 8-byte mode), s_tdata[127:64] the
// colour half, s_tlast marks the final block of a texture.
// Output channel m_*: one item per input block with the running counts; on the
// final block m_tlast is high and the two Q1.RATIO_BITS ratios are filled in.
// Configuration: cfg_we/cfg_addr/cfg_wdata write block_format (0),
// clear_threshold (1) and black_limit (2); write only while the block is idle.
//
// A non-final block is registered into the output register on acceptance and
// shows its result in the next cycle; one block per cycle is sustained while
// the receiver keeps up. A final block runs two restoring divisions on one
// shared subtract/compare unit: a setup step plus RATIO_BITS shift-subtract
// steps each, with the steps skipped when a divisor is zero or a ratio is one;
// s_tready stays low meanwhile.
// Reset clears all counters and restores the register defaults. When the
// receiver stalls, the result stays in the output register and s_tready drops
// until it is taken.
module block_alpha_coverage_stats #(
    parameter int COUNT_WIDTH = 32,
    parameter int RATIO_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fields from bit 0: block_word_a[63:0], block_word_b[127:64]
    input  logic [bacs_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,   // last_block
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fields from bit 0: zero_texels[31:0], total_texels[63:32],
    // clear_blocks[95:64], black_blocks[127:96], alpha_zero_ratio[144:128],
    // black_ratio[161:145], zero pad[167:162]
    output logic [bacs_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,   // ratio_valid
    input  logic                               cfg_we,
    input  logic [bacs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bacs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CW       = COUNT_WIDTH;
    localparam int RB       = RATIO_BITS;
    localparam int StepW    = $clog2(RATIO_BITS);
    localparam int CntOutW  = bacs_pkg::CNT_OUT_W;
    localparam int RatOutW  = bacs_pkg::RATIO_OUT_W;
    localparam int PadW     = bacs_pkg::OUT_PAD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV
    } state_t;

    // Control registers
    state_t             state_reg, state_next;
    logic               phase_reg, phase_next;
    logic [StepW-1:0]   step_reg, step_next;
    logic [CW-1:0]      zero_cnt_reg, zero_cnt_next;
    logic [CW-1:0]      texel_cnt_reg, texel_cnt_next;
    logic [CW-1:0]      clear_cnt_reg, clear_cnt_next;
    logic [CW-1:0]      black_cnt_reg, black_cnt_next;
    logic               fmt_reg, fmt_next;
    logic [4:0]         clear_thr_reg, clear_thr_next;
    logic [15:0]        black_lim_reg, black_lim_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Payload registers
    logic [CW-1:0]      num0_reg, num0_next;
    logic [CW-1:0]      den0_reg, den0_next;
    logic [CW-1:0]      num1_reg, num1_next;
    logic [CW-1:0]      den1_reg, den1_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [RB-1:0]      quo_reg, quo_next;
    logic [RB:0]        ratio0_reg, ratio0_next;
    logic [bacs_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    // Block classification
    logic [63:0]        word_a;
    logic [63:0]        word_b;
    logic [4:0]         zeros;
    logic               is_clear;
    logic               is_black;
    logic [CW:0]        zero_sum, texel_sum, clear_sum, black_sum;
    logic [CW-1:0]      zero_new, texel_new, clear_new, black_new;

    // Shared subtract/compare unit
    logic [CW-1:0]      num_sel;
    logic [CW-1:0]      den_sel;
    logic [CW:0]        sub_a;
    logic [CW+1:0]      diff;
    logic               ge;
    logic               den_zero;

    logic               s_fire;
    logic               finish;
    logic [RB:0]        q_final;

    assign word_a = s_tdata[63:0];
    assign word_b = s_tdata[127:64];

    assign zeros = (fmt_reg == bacs_pkg::FMT_BC1) ? bacs_pkg::count_bc1_zeros(word_a)
                                                  : bacs_pkg::count_bc2_zeros(word_a);
    assign is_clear = (fmt_reg == bacs_pkg::FMT_BC2) && (zeros >= clear_thr_reg);
    assign is_black = is_clear && (word_b[15:0] < black_lim_reg)
                               && (word_b[31:16] < black_lim_reg);

    // Saturating counter updates
    assign zero_sum  = {1'b0, zero_cnt_reg}  + (CW+1)'(zeros);
    assign texel_sum = {1'b0, texel_cnt_reg} + (CW+1)'(bacs_pkg::TEXELS_PER_BLOCK);
    assign clear_sum = {1'b0, clear_cnt_reg} + (CW+1)'(is_clear);
    assign black_sum = {1'b0, black_cnt_reg} + (CW+1)'(is_black);
    assign zero_new  = zero_sum[CW]  ? '1 : zero_sum[CW-1:0];
    assign texel_new = texel_sum[CW] ? '1 : texel_sum[CW-1:0];
    assign clear_new = clear_sum[CW] ? '1 : clear_sum[CW-1:0];
    assign black_new = black_sum[CW] ? '1 : black_sum[CW-1:0];

    // Divider: setup compares num with den, each step compares 2r with den
    assign num_sel  = phase_reg ? num1_reg : num0_reg;
    assign den_sel  = phase_reg ? den1_reg : den0_reg;
    assign den_zero = (den_sel == '0);
    assign sub_a    = (state_reg == S_PREP) ? {1'b0, num_sel} : {rem_reg, 1'b0};
    assign diff     = {1'b0, sub_a} - {2'b00, den_sel};
    assign ge       = !diff[CW+1];

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        zero_cnt_next  = zero_cnt_reg;
        texel_cnt_next = texel_cnt_reg;
        clear_cnt_next = clear_cnt_reg;
        black_cnt_next = black_cnt_reg;
        fmt_next       = fmt_reg;
        clear_thr_next = clear_thr_reg;
        black_lim_next = black_lim_reg;
        m_tvalid_next  = m_tvalid_reg;
        num0_next      = num0_reg;
        den0_next      = den0_reg;
        num1_next      = num1_reg;
        den1_next      = den1_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        ratio0_next    = ratio0_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        finish         = 1'b0;
        q_final        = '0;

        // Drop the result once the receiver takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_addr)
                bacs_pkg::REG_BLOCK_FORMAT:    fmt_next       = cfg_wdata[0];
                bacs_pkg::REG_CLEAR_THRESHOLD: clear_thr_next = cfg_wdata[4:0];
                bacs_pkg::REG_BLACK_LIMIT:     black_lim_next = cfg_wdata[15:0];
                default:                       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tlast)
                    begin
                        // Hold the final counts as divider operands, restart counting
                        num0_next      = zero_new;
                        den0_next      = texel_new;
                        num1_next      = black_new;
                        den1_next      = clear_new;
                        zero_cnt_next  = '0;
                        texel_cnt_next = '0;
                        clear_cnt_next = '0;
                        black_cnt_next = '0;
                        phase_next     = 1'b0;
                        state_next     = S_PREP;
                    end
                    else
                    begin
                        zero_cnt_next  = zero_new;
                        texel_cnt_next = texel_new;
                        clear_cnt_next = clear_new;
                        black_cnt_next = black_new;
                        m_tvalid_next  = 1'b1;
                        m_tlast_next   = 1'b0;
                        m_tdata_next   = {{PadW{1'b0}}, {RatOutW{1'b0}}, {RatOutW{1'b0}},
                                          CntOutW'(black_new), CntOutW'(clear_new),
                                          CntOutW'(texel_new), CntOutW'(zero_new)};
                    end
                end
            end
            S_PREP:
            begin
                if (den_zero)
                begin
                    finish  = 1'b1;
                    q_final = '0;
                end
                else if (ge)
                begin
                    // Ratio of one or more: exactly one
                    finish  = 1'b1;
                    q_final = {1'b1, {RB{1'b0}}};
                end
                else
                begin
                    rem_next   = sub_a[CW-1:0];
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = ge ? diff[CW-1:0] : sub_a[CW-1:0];
                quo_next  = {quo_reg[RB-2:0], ge};
                step_next = step_reg + StepW'(1);
                if (step_reg == StepW'(RB - 1))
                begin
                    finish  = 1'b1;
                    q_final = {1'b0, quo_reg[RB-2:0], ge};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            if (!phase_reg)
            begin
                ratio0_next = q_final;
                phase_next  = 1'b1;
                state_next  = S_PREP;
            end
            else
            begin
                m_tvalid_next = 1'b1;
                m_tlast_next  = 1'b1;
                m_tdata_next  = {{PadW{1'b0}}, RatOutW'(q_final), RatOutW'(ratio0_reg),
                                 CntOutW'(num1_reg), CntOutW'(den1_reg),
                                 CntOutW'(den0_reg), CntOutW'(num0_reg)};
                state_next    = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            step_reg      <= '0;
            zero_cnt_reg  <= '0;
            texel_cnt_reg <= '0;
            clear_cnt_reg <= '0;
            black_cnt_reg <= '0;
            fmt_reg       <= bacs_pkg::FMT_BC2;
            clear_thr_reg <= bacs_pkg::CLEAR_THRESHOLD_RST;
            black_lim_reg <= bacs_pkg::BLACK_LIMIT_RST;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            zero_cnt_reg  <= zero_cnt_next;
            texel_cnt_reg <= texel_cnt_next;
            clear_cnt_reg <= clear_cnt_next;
            black_cnt_reg <= black_cnt_next;
            fmt_reg       <= fmt_next;
            clear_thr_reg <= clear_thr_next;
            black_lim_reg <= black_lim_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num0_reg    <= num0_next;
        den0_reg    <= den0_next;
        num1_reg    <= num1_next;
        den1_reg    <= den1_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        ratio0_reg  <= ratio0_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/bacs_checker.sv
module bacs_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [bacs_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               m_tlast
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

    // No new item while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted over a stalled result");

    // Ratios stay zero except on the final block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[161:128] == 34'd0)
    else $error("ratio fields set on a non-final block");

    // Texel count grows by whole blocks, or sits saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[35:32] == 4'h0 || m_tdata[35:32] == 4'hF)
    else $error("texel count not a whole number of blocks");

endmodule

bind block_alpha_coverage_stats bacs_checker u_bacs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
